>>> hw/rtl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg: shared definitions for the huffman tree loader and decoder
// Phase codes, field widths and parameter defaults used across the block.
// ----------------------------------------------------------------------------
package htd_pkg;

	// default sizes of the node store and the pending stack
	localparam int NODE_DEPTH_DEF  = 512;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int ENTRY_W_DEF     = 10;

	// fixed field widths
	localparam int SYM_W   = 8;
	localparam int COUNT_W = 32;
	localparam int CNT_W   = 3;

	// phase codes
	localparam int PH_W = 2;
	localparam logic [PH_W-1:0] PH_FLAG   = 2'd0;
	localparam logic [PH_W-1:0] PH_BYTE   = 2'd1;
	localparam logic [PH_W-1:0] PH_DECODE = 2'd2;
	localparam logic [PH_W-1:0] PH_WAIT   = 2'd3;

	// last bit position of a symbol while shifting it in
	localparam logic [CNT_W-1:0] CNT_LAST = 3'd7;

endpackage

>>> hw/rtl/htd_mem.sv
// ----------------------------------------------------------------------------
// htd_mem: single write port, single read port synchronous memory
// One write per cycle; read data is registered and appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module htd_mem #(
	parameter int DEPTH = htd_pkg::NODE_DEPTH_DEF,
	parameter int WIDTH = htd_pkg::ENTRY_W_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/huffman_tree_load_and_decode.sv
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode: pre-order huffman tree loader and bit decoder
// Rebuilds a serialized tree into a node store, then walks it one bit a beat.
// An accepted input beat is registered, then worked into the output register
// once that is free; no new beat is taken until then. The node store read of
// the child picked by a bit is issued with the bit and used when it is worked.
// Reset: control state clears asynchronously; node store and stack contents
// are undefined until loaded by a tree, no clearing pass.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode #(
	parameter int NODE_DEPTH  = htd_pkg::NODE_DEPTH_DEF,
	parameter int STACK_DEPTH = htd_pkg::STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [htd_pkg::COUNT_W-1:0] cfg_write_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        bit_value,
	input  logic                        stream_start,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [htd_pkg::SYM_W-1:0]   symbol,
	output logic                        last_symbol,
	output logic                        tree_error
);
	import htd_pkg::*;

	localparam int NAW = $clog2(NODE_DEPTH);
	localparam int NCW = $clog2(NODE_DEPTH + 1);
	localparam int PW  = (NAW > SYM_W) ? NAW : SYM_W;
	localparam int EW  = PW + 1;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);

	// state registers
	logic [COUNT_W-1:0] count_cfg_q;
	logic [PH_W-1:0]    phase_q, phase_d;
	logic [SCW-1:0]     sp_q, sp_d;
	logic [NCW-1:0]     next_q, next_d;
	logic [NAW-1:0]     cur_q, cur_d;
	logic [EW-1:0]      cur_entry_q, cur_entry_d;
	logic [EW-1:0]      root_q;
	logic [SYM_W-1:0]   shift_q, shift_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [COUNT_W-1:0] left_q, left_d;
	logic               busy_q;
	logic               bit_s1;
	logic [NAW-1:0]     child_s1;

	// output register
	logic               out_valid_q;
	logic [SYM_W-1:0]   symbol_q;
	logic               last_q;
	logic               err_q;

	// handshake and control
	logic               accept;
	logic               out_free;
	logic               advance;
	logic [PH_W-1:0]    phase_a;
	logic               cur_leaf;
	logic [NAW-1:0]     child_a;
	logic               node_re;
	logic               stack_re;
	logic               leaf_wr_a;
	logic               push_b;
	logic               pop_b;

	// memory ports
	logic               node_we;
	logic [NAW-1:0]     node_waddr;
	logic [EW-1:0]      node_wdata;
	logic [EW-1:0]      node_rdata;
	logic               stack_we;
	logic [SAW-1:0]     stack_raddr;
	logic [NAW-1:0]     stack_rdata;
	logic [SCW-1:0]     sp_dec;

	// result of the advance cycle
	logic               res_valid;
	logic [SYM_W-1:0]   res_sym;
	logic               res_last;
	logic               res_err;

	// input beat registered when accepted, worked once the output register is free
	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = busy_q && out_free;

	// accept cycle: phase after a possible restart, reads and leaf write
	assign phase_a   = stream_start ? PH_FLAG : phase_q;
	assign cur_leaf  = cur_entry_q[EW-1];
	assign child_a   = bit_value ? cur_entry_q[NAW-1:0] : cur_q + 1'b1;
	assign node_re   = accept && (phase_a == PH_DECODE) && !cur_leaf;
	assign sp_dec    = sp_q - 1'b1;
	assign stack_raddr = sp_dec[SAW-1:0];
	assign stack_re  = accept && (phase_a == PH_BYTE) && (cnt_q == CNT_LAST) && (sp_q != '0);
	assign leaf_wr_a = accept && (phase_a == PH_BYTE) && (cnt_q == CNT_LAST);

	// advance cycle: internal node push and right child link
	assign push_b = advance && (phase_q == PH_FLAG) && (next_q != NCW'(NODE_DEPTH))
		&& !bit_s1 && (sp_q != SCW'(STACK_DEPTH));
	assign pop_b  = advance && (phase_q == PH_BYTE) && (cnt_q == CNT_LAST) && (sp_q != '0);
	assign stack_we = push_b;

	// node store write mux, accept and advance cycles never coincide
	always_comb begin
		node_we    = 1'b0;
		node_waddr = cur_q;
		node_wdata = '0;
		if (leaf_wr_a) begin
			node_we    = 1'b1;
			node_waddr = cur_q;
			node_wdata = {1'b1, PW'({shift_q[SYM_W-2:0], bit_value})};
		end else if (push_b) begin
			node_we    = 1'b1;
			node_waddr = next_q[NAW-1:0];
			node_wdata = '0;
		end else if (pop_b) begin
			node_we    = 1'b1;
			node_waddr = stack_rdata;
			node_wdata = {1'b0, PW'(next_q[NAW-1:0])};
		end
	end

	htd_mem #(
		.DEPTH (NODE_DEPTH),
		.WIDTH (EW)
	) u_node_mem (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (child_a),
		.rdata (node_rdata)
	);

	htd_mem #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (NAW)
	) u_stack_mem (
		.clk   (clk),
		.we    (stack_we),
		.waddr (sp_q[SAW-1:0]),
		.wdata (next_q[NAW-1:0]),
		.re    (stack_re),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

	// next state and result
	always_comb begin
		phase_d     = phase_q;
		sp_d        = sp_q;
		next_d      = next_q;
		cur_d       = cur_q;
		cur_entry_d = cur_entry_q;
		shift_d     = shift_q;
		cnt_d       = cnt_q;
		left_d      = left_q;
		res_valid   = 1'b0;
		res_sym     = '0;
		res_last    = 1'b0;
		res_err     = 1'b0;

		// restart of tree loading with the beat that carries it
		if (accept && stream_start) begin
			phase_d = PH_FLAG;
			sp_d    = '0;
			next_d  = '0;
			cur_d   = '0;
			shift_d = '0;
			cnt_d   = '0;
			left_d  = '0;
		end

		if (advance) begin
			unique case (phase_q)
				PH_FLAG: begin
					if (next_q == NCW'(NODE_DEPTH)) begin
						phase_d   = PH_WAIT;
						res_valid = 1'b1;
						res_err   = 1'b1;
					end else if (bit_s1) begin
						cur_d   = next_q[NAW-1:0];
						next_d  = next_q + 1'b1;
						shift_d = '0;
						cnt_d   = '0;
						phase_d = PH_BYTE;
					end else if (sp_q == SCW'(STACK_DEPTH)) begin
						phase_d   = PH_WAIT;
						res_valid = 1'b1;
						res_err   = 1'b1;
					end else begin
						sp_d   = sp_q + 1'b1;
						next_d = next_q + 1'b1;
					end
				end
				PH_BYTE: begin
					shift_d = {shift_q[SYM_W-2:0], bit_s1};
					if (cnt_q != CNT_LAST) begin
						cnt_d = cnt_q + 1'b1;
					end else begin
						cnt_d = '0;
						if (sp_q == '0) begin
							// tree complete, start at the root
							cur_d       = '0;
							cur_entry_d = root_q;
							left_d      = count_cfg_q;
							phase_d     = (count_cfg_q == '0) ? PH_WAIT : PH_DECODE;
						end else begin
							sp_d    = sp_dec;
							phase_d = PH_FLAG;
						end
					end
				end
				PH_DECODE: begin
					if (cur_leaf || node_rdata[EW-1]) begin
						res_valid   = 1'b1;
						res_sym     = cur_leaf ? cur_entry_q[SYM_W-1:0] : node_rdata[SYM_W-1:0];
						res_last    = (left_q == COUNT_W'(1));
						left_d      = left_q - 1'b1;
						cur_d       = '0;
						cur_entry_d = root_q;
						if (left_q == COUNT_W'(1)) begin
							phase_d = PH_WAIT;
						end
					end else begin
						cur_d       = child_s1;
						cur_entry_d = node_rdata;
					end
				end
				PH_WAIT: begin
					phase_d = phase_q;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= '0;
			phase_q     <= PH_FLAG;
			sp_q        <= '0;
			next_q      <= '0;
			cur_q       <= '0;
			cur_entry_q <= '0;
			root_q      <= '0;
			shift_q     <= '0;
			cnt_q       <= '0;
			left_q      <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				count_cfg_q <= cfg_write_data;
			end
			phase_q     <= phase_d;
			sp_q        <= sp_d;
			next_q      <= next_d;
			cur_q       <= cur_d;
			cur_entry_q <= cur_entry_d;
			shift_q     <= shift_d;
			cnt_q       <= cnt_d;
			left_q      <= left_d;
			// shadow of the root entry so the walk can restart without a read
			if (node_we && (node_waddr == '0)) begin
				root_q <= node_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (advance) begin
				busy_q <= 1'b0;
			end
			if (advance && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// first stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			bit_s1   <= bit_value;
			child_s1 <= child_a;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			symbol_q <= res_sym;
			last_q   <= res_last;
			err_q    <= res_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign symbol      = symbol_q;
	assign last_symbol = last_q;
	assign tree_error  = err_q;

endmodule

>>> sim/huffman_tree_load_and_decode_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode_tb: self-checking bench for the tree decoder
// Feeds pre-order tree descriptions and code bits one beat at a time. A
// behavioral copy of the loader and walker predicts every result beat, which
// is compared field by field as it leaves the block. Both sides idle at
// random, the output side holds off for a long stretch, and the stimulus
// covers single-leaf trees, stack overflow, zero and all-ones
// symbol counts, cut-short trees and restarts in the middle of decoding.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode_tb;
	import htd_pkg::*;

	localparam int NODES          = NODE_DEPTH_DEF;
	localparam int STACK_SLOTS    = STACK_DEPTH_DEF;
	localparam int LEAF_POS       = ENTRY_W_DEF - 1;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_BEATS   = 150;
	localparam int CODE_CAP       = 150;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
		logic             err;
	} decoded_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write_en = 1'b0;
	logic [COUNT_W-1:0]   cfg_write_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 bit_value = 1'b0;
	logic                 stream_start = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SYM_W-1:0]     symbol;
	logic                 last_symbol;
	logic                 tree_error;

	// expected result beats, oldest first
	decoded_t             expected_q[$];

	// shadow of the loader and walker
	logic [ENTRY_W_DEF-1:0] node_table [NODES];
	logic [8:0]           open_nodes [STACK_SLOTS];
	int unsigned          open_cnt;
	int unsigned          fill_ptr;
	logic [8:0]           walk_node;
	logic [PH_W-1:0]      walk_phase;
	logic [SYM_W-1:0]     sym_acc;
	logic [CNT_W-1:0]     sym_bits;
	logic [COUNT_W-1:0]   left_cnt;
	logic [COUNT_W-1:0]   count_reg = '0;

	// run control and bookkeeping
	bit                   tx_idle_on = 1'b0;
	bit                   rx_idle_on = 1'b0;
	bit                   hold_request = 1'b0;
	int unsigned          fail_cnt = 0;
	int unsigned          all_beats = 0;
	int unsigned          live_beats = 0;
	int unsigned          checked_beats = 0;
	int unsigned          error_beats = 0;
	int unsigned          stream_cnt = 0;
	int unsigned          quiet_cycles = 0;

	huffman_tree_load_and_decode DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.bit_value      (bit_value),
		.stream_start   (stream_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.symbol         (symbol),
		.last_symbol    (last_symbol),
		.tree_error     (tree_error)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// back to tree load, nothing pending
	function automatic void restart_tree();
		open_cnt   = 0;
		fill_ptr   = 0;
		walk_node  = '0;
		walk_phase = PH_FLAG;
		sym_acc    = '0;
		sym_bits   = '0;
		left_cnt   = '0;
	endfunction

	// add one predicted result beat at the tail
	function automatic void queue_beat(input decoded_t d);
		expected_q.insert(expected_q.size(), d);
	endfunction

	// advance the shadow by one accepted input beat
	function automatic void track_bit(input logic b, input logic ss);
		logic [ENTRY_W_DEF-1:0] entry;
		logic [8:0]             child;
		if (ss)
			restart_tree();
		case (walk_phase)
			PH_FLAG: begin
				if (fill_ptr >= NODES) begin
					// node store full
					walk_phase = PH_WAIT;
					queue_beat(decoded_t'{sym: '0, last: 1'b0, err: 1'b1});
				end else if (b) begin
					walk_node  = 9'(fill_ptr);
					fill_ptr++;
					sym_acc    = '0;
					sym_bits   = '0;
					walk_phase = PH_BYTE;
				end else if (open_cnt >= STACK_SLOTS) begin
					// pending stack full
					walk_phase = PH_WAIT;
					queue_beat(decoded_t'{sym: '0, last: 1'b0, err: 1'b1});
				end else begin
					node_table[fill_ptr] = '0;
					open_nodes[open_cnt] = 9'(fill_ptr);
					open_cnt++;
					fill_ptr++;
				end
			end
			PH_BYTE: begin
				sym_acc = {sym_acc[SYM_W-2:0], b};
				if (sym_bits != CNT_LAST) begin
					sym_bits++;
				end else begin
					sym_bits = '0;
					node_table[walk_node] = {1'b1, 1'b0, sym_acc};
					if (open_cnt == 0) begin
						// tree complete: count is taken here
						walk_node  = '0;
						left_cnt   = count_reg;
						walk_phase = (left_cnt == 0) ? PH_WAIT : PH_DECODE;
					end else begin
						// latest open internal node gets its right child
						open_cnt--;
						node_table[open_nodes[open_cnt]] = {1'b0, 9'(fill_ptr)};
						walk_phase = PH_FLAG;
					end
				end
			end
			PH_DECODE: begin
				entry = node_table[walk_node];
				if (!entry[LEAF_POS]) begin
					child = b ? entry[8:0] : walk_node + 9'd1;
					entry = node_table[child];
					if (!entry[LEAF_POS])
						walk_node = child;
				end
				if (entry[LEAF_POS]) begin
					walk_node = '0;
					left_cnt  = left_cnt - 1;
					if (left_cnt == 0)
						walk_phase = PH_WAIT;
					queue_beat(decoded_t'{sym: entry[SYM_W-1:0], last: (left_cnt == 0),
						err: 1'b0});
				end
			end
			default: ;
		endcase
	endfunction

	// offer one input beat and wait until it is taken
	task automatic send_beat(input logic b, input logic ss);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		bit_value    <= b;
		stream_start <= ss;
		do @(posedge clk); while (in_stall);
		all_beats++;
		if (ss || walk_phase != PH_WAIT)
			live_beats++;
		if (ss)
			stream_cnt++;
		track_bit(b, ss);
	endtask

	// leaf flag then its symbol, msb first
	task automatic send_leaf(input logic [SYM_W-1:0] sym, input logic ss);
		int i;
		send_beat(1'b1, ss);
		for (i = SYM_W - 1; i >= 0; i--)
			send_beat(sym[i], 1'b0);
	endtask

	task automatic send_padding(input int unsigned n);
		repeat (n) send_beat(1'($urandom), 1'b0);
	endtask

	// random well-formed tree with at most max_leaves leaves
	task automatic send_tree(input int unsigned max_leaves, input logic ss);
		int unsigned slots;
		int unsigned leaves;
		logic        first;
		logic [SYM_W-1:0] sym;
		slots  = 1;
		leaves = 0;
		first  = ss;
		while (slots > 0) begin
			// an internal node adds one more leaf to the finished tree
			if (leaves + slots < max_leaves && $urandom_range(0, 1) == 1) begin
				send_beat(1'b0, first);
				slots++;
			end else begin
				case ($urandom_range(0, 5))
					0:       sym = '0;
					1:       sym = '1;
					default: sym = SYM_W'($urandom);
				endcase
				send_leaf(sym, first);
				slots--;
				leaves++;
			end
			first = 1'b0;
		end
	endtask

	// random code bits while the walker is still decoding
	task automatic send_codes(input int unsigned cap);
		int unsigned n;
		for (n = 0; n < cap && walk_phase == PH_DECODE; n++)
			send_beat(1'($urandom), 1'b0);
	endtask

	// stop offering, let every expected beat drain, then let the block settle
	task automatic go_quiet();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] value);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en   <= 1'b0;
		count_reg = value;
	endtask

	// a lone leaf as root, first bit sent straight after reset without restart
	task automatic test_single_leaf();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		go_quiet();
		write_count(32'd3);
		send_leaf(8'hA5, 1'b0);
		send_beat(1'b0, 1'b0);
		send_beat(1'b1, 1'b0);
		send_beat(1'b1, 1'b0);
		send_padding(2);
	endtask

	// small fixed tree, both branch directions, then a tree cut off mid-symbol
	task automatic test_fixed_tree();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		go_quiet();
		write_count(32'd4);
		send_beat(1'b0, 1'b1);
		send_beat(1'b0, 1'b0);
		send_leaf(8'h00, 1'b0);
		send_leaf(8'hFF, 1'b0);
		send_leaf(8'h80, 1'b0);
		// codes 00, 01, 1, 1
		send_beat(1'b0, 1'b0);
		send_beat(1'b0, 1'b0);
		send_beat(1'b0, 1'b0);
		send_beat(1'b1, 1'b0);
		send_beat(1'b1, 1'b0);
		send_beat(1'b1, 1'b0);
		send_padding(2);
		// restart in the middle of a leaf symbol
		send_beat(1'b0, 1'b1);
		send_beat(1'b1, 1'b0);
		send_padding(3);
		send_leaf(8'h5A, 1'b1);
		send_padding(6);
	endtask

	// zero count, all-ones count with a restart while decoding, count of one
	task automatic test_count_extremes();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b0;
		go_quiet();
		write_count('0);
		send_tree(3, 1'b1);
		send_padding(4);
		go_quiet();
		write_count('1);
		send_tree(4, 1'b1);
		send_codes(12);
		send_tree(2, 1'b1);
		send_codes(6);
		go_quiet();
		write_count(32'd1);
		send_tree(5, 1'b1);
		send_codes(CODE_CAP);
		send_padding(2);
	endtask

	// one internal node more than the pending stack holds
	task automatic test_stack_overflow();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		go_quiet();
		send_beat(1'b0, 1'b1);
		repeat (STACK_SLOTS) send_beat(1'b0, 1'b0);
		send_padding(3);
		send_tree(2, 1'b1);
		send_codes(CODE_CAP);
	endtask

	// output held off for a long stretch while code bits keep coming
	task automatic test_output_hold();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		go_quiet();
		write_count(32'd64);
		send_tree(3, 1'b1);
		hold_request = 1'b1;
		send_codes(80);
		// input side waits for every result before going on
		go_quiet();
	endtask

	// mostly well-formed streams, some cut short, some plain noise
	task automatic test_random_streams();
		int unsigned        goal;
		int unsigned        kind;
		logic [COUNT_W-1:0] cnt;
		goal = live_beats + RANDOM_BEATS;
		while (live_beats < goal) begin
			tx_idle_on = ($urandom_range(0, 2) != 0);
			rx_idle_on = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 7))
				0:       cnt = '0;
				1:       cnt = '1;
				2:       cnt = 32'd1;
				default: cnt = $urandom_range(2, 12);
			endcase
			go_quiet();
			write_count(cnt);
			repeat ($urandom_range(3, 6)) begin
				if (live_beats >= goal)
					break;
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					send_tree(($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8), 1'b1);
					send_codes(CODE_CAP);
					send_padding($urandom_range(0, 3));
				end else if (kind < 9) begin
					// tree left to random bits, which seldom complete it before the next restart
					send_beat(1'b0, 1'b1);
					send_padding($urandom_range(1, 20));
				end else begin
					repeat ($urandom_range(5, 30))
						send_beat(1'($urandom), ($urandom_range(0, 15) == 0));
				end
			end
		end
		go_quiet();
	endtask

	// output side: random stall after each beat, long hold on request
	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				stall_left = rx_idle_on ? $urandom_range(0, 12) : 0;
			if (hold_request) begin
				stall_left   = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : result_check
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			checked_beats++;
			if (tree_error)
				error_beats++;
			if (expected_q.size() == 0) begin
				$error("unexpected result beat: symbol %0h last %0b error %0b",
					symbol, last_symbol, tree_error);
				fail_cnt++;
			end else begin
				want = expected_q.pop_front();
				if (symbol !== want.sym) begin
					$error("symbol: expected %0h, got %0h", want.sym, symbol);
					fail_cnt++;
				end
				if (last_symbol !== want.last) begin
					$error("last_symbol: expected %0b, got %0b", want.last, last_symbol);
					fail_cnt++;
				end
				if (tree_error !== want.err) begin
					$error("tree_error: expected %0b, got %0b", want.err, tree_error);
					fail_cnt++;
				end
			end
		end
	end

	// stop a hung run: too long without any beat on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("huffman_tree_load_and_decode_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		node_table = '{default: '0};
		restart_tree();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_leaf();
		test_fixed_tree();
		test_count_extremes();
		test_stack_overflow();
		test_output_hold();
		test_random_streams();

		if (expected_q.size() != 0) begin
			$error("%0d predicted result beats never arrived", expected_q.size());
			fail_cnt++;
		end
		$display("summary: %0d input beats (%0d outside padding), %0d result beats checked",
			all_beats, live_beats, checked_beats);
		$display("summary: %0d restarts, %0d overflow beats, long output hold and idle gaps",
			stream_cnt, error_beats);
		if (fail_cnt == 0)
			$display("huffman_tree_load_and_decode_tb: done, clean");
		else
			$display("huffman_tree_load_and_decode_tb: done, errors");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/htd_pkg.sv
hw/rtl/htd_mem.sv
hw/rtl/huffman_tree_load_and_decode.sv
sim/huffman_tree_load_and_decode_tb.sv
